// ----- hw/rtl/bti_pkg.sv -----
// shared types and constants for the breakpoint table interpolator
// no dependencies
package bti_pkg;
    localparam int DefTableDepth = 16;
    localparam int NumCols       = 8;
    localparam int KeyW          = 8;
    localparam int ValW          = 32;
    localparam int FracW         = 16;
    localparam int CountW        = 5;

    typedef enum logic [2:0] {
        DP_NOP, DP_LOAD, DP_SCAN, DP_RD_A, DP_RD_B, DP_DIV, DP_MUL, DP_EMIT
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
        logic    emit_zero;
        logic    emit_entry;
    } dp_ctrl_t;

    typedef struct packed {
        logic scan_done;
        logic found_first;
        logic found_none;
        logic div_done;
        logic mul_done;
    } dp_stat_t;
endpackage

// ----- hw/rtl/bti_datapath.sv -----
// table storage, search, divider and multiply-accumulate datapath
// depends on bti_pkg
module bti_datapath #(
    parameter int TABLE_DEPTH = bti_pkg::DefTableDepth
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bti_pkg::dp_ctrl_t                    ctrl,
    output bti_pkg::dp_stat_t                    stat,
    input  logic                                 wr_en,
    input  logic [3:0]                           wr_index,
    input  logic [bti_pkg::KeyW-1:0]             wr_key,
    input  logic [bti_pkg::NumCols*bti_pkg::ValW-1:0] wr_vals,
    input  logic [bti_pkg::KeyW-1:0]             q_key,
    input  logic [bti_pkg::CountW-1:0]           entry_count,
    output logic [bti_pkg::KeyW-1:0]             res_key,
    output logic [bti_pkg::NumCols*bti_pkg::ValW-1:0] res_vals
);
    import bti_pkg::*;
    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ScanW = IdxW + 1;
    localparam int ColW = $clog2(NumCols);

    logic [KeyW-1:0]             keys_mem [TABLE_DEPTH];
    logic [NumCols*ValW-1:0]     vals_mem [TABLE_DEPTH];

    logic [ScanW-1:0] n_lim;
    logic [ScanW-1:0] idx_reg, idx_next;
    logic [KeyW-1:0]  q_reg;
    logic [KeyW-1:0]  ka_reg, kb_reg, rd_key_reg;
    logic [NumCols*ValW-1:0] rd_vals_reg, a_reg, b_reg;
    logic [FracW-1:0] quo_reg;
    logic [KeyW:0]    rem_reg;
    logic [4:0]       div_cnt_reg;
    logic [ColW:0]    col_reg;
    logic [KeyW-1:0]  keyo_reg;
    logic [NumCols*ValW-1:0] outv_reg;

    assign n_lim = (int'(entry_count) > TABLE_DEPTH) ? ScanW'(TABLE_DEPTH)
                                                      : ScanW'(entry_count);

    always_ff @(posedge clk)
    begin
        if (wr_en && (int'(wr_index) < TABLE_DEPTH))
        begin
            keys_mem[IdxW'(wr_index)] <= wr_key;
            vals_mem[IdxW'(wr_index)] <= wr_vals;
        end
        rd_key_reg  <= keys_mem[idx_next[IdxW-1:0]];
        rd_vals_reg <= vals_mem[idx_next[IdxW-1:0]];
    end

    // scan index, next read address
    always_comb
    begin
        idx_next = idx_reg;
        case (ctrl.cmd)
            DP_LOAD: idx_next = '0;
            DP_SCAN:
                if (!stat.scan_done) idx_next = idx_reg + 1'b1;
                else if (idx_reg != '0 && idx_reg != n_lim) idx_next = idx_reg - 1'b1;
                else if (idx_reg == n_lim) idx_next = idx_reg - 1'b1;
            DP_RD_A: idx_next = idx_reg + 1'b1;
            default: idx_next = idx_reg;
        endcase
    end

    // scan hit: rd_key_reg holds key at idx_reg
    logic hit;
    assign hit = (idx_reg == n_lim) || (rd_key_reg > q_reg);
    assign stat.scan_done   = hit;
    assign stat.found_first = hit && idx_reg == '0;
    assign stat.found_none  = hit && idx_reg == n_lim;
    assign stat.div_done    = div_cnt_reg == 5'd16;
    assign stat.mul_done    = col_reg == (ColW+1)'(NumCols);

    logic [KeyW-1:0] dk;
    logic [KeyW:0]   rem_sh;
    assign dk = kb_reg - ka_reg;
    assign rem_sh = {rem_reg[KeyW-1:0], 1'b0};

    logic signed [ValW:0]    diff;
    logic signed [ValW+FracW+1:0] prod;
    logic [ValW-1:0]         a_col;
    assign a_col = a_reg[col_reg[ColW-1:0]*ValW +: ValW];
    assign diff  = $signed({b_reg[col_reg[ColW-1:0]*ValW+ValW-1],
                            b_reg[col_reg[ColW-1:0]*ValW +: ValW]})
                 - $signed({a_col[ValW-1], a_col});
    assign prod  = diff * $signed({1'b0, quo_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            div_cnt_reg <= '0;
            col_reg     <= '0;
            q_reg       <= '0;
            ka_reg      <= '0;
            kb_reg      <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            keyo_reg    <= '0;
            outv_reg    <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            unique case (ctrl.cmd)
                DP_LOAD:
                begin
                    q_reg <= q_key;
                    div_cnt_reg <= '0;
                    col_reg <= '0;
                end
                DP_RD_A:
                begin
                    ka_reg <= rd_key_reg;
                    a_reg  <= rd_vals_reg;
                end
                DP_RD_B:
                begin
                    kb_reg  <= rd_key_reg;
                    b_reg   <= rd_vals_reg;
                    rem_reg <= {1'b0, q_reg - ka_reg};
                    quo_reg <= '0;
                end
                DP_DIV:
                begin
                    // restoring division of (q-ka)<<16 by kb-ka, one bit a cycle
                    if (rem_sh >= {1'b0, dk})
                    begin
                        rem_reg <= rem_sh - {1'b0, dk};
                        quo_reg <= {quo_reg[FracW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[FracW-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                DP_MUL:
                begin
                    outv_reg[col_reg[ColW-1:0]*ValW +: ValW] <=
                        a_col + prod[ValW+FracW-1:FracW];
                    col_reg <= col_reg + 1'b1;
                    keyo_reg <= q_reg;
                end
                DP_EMIT:
                begin
                    if (ctrl.emit_zero)
                    begin
                        keyo_reg <= '0;
                        outv_reg <= '0;
                    end
                    else if (ctrl.emit_entry)
                    begin
                        keyo_reg <= rd_key_reg;
                        outv_reg <= rd_vals_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign res_key  = keyo_reg;
    assign res_vals = outv_reg;
endmodule

// ----- hw/rtl/bti_ctrl.sv -----
// query sequencer for the breakpoint table interpolator
// depends on bti_pkg
module bti_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [bti_pkg::CountW-1:0] entry_count,
    output logic              out_valid,
    input  logic              out_stall,
    output bti_pkg::dp_ctrl_t ctrl,
    input  bti_pkg::dp_stat_t stat,
    output logic              wr_en
);
    import bti_pkg::*;
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_LAST, S_RDA, S_RDB, S_DIV, S_MUL, S_OUT
    } state_t;
    state_t state_reg;
    logic   out_valid_reg;

    assign in_stall = state_reg != S_IDLE;
    assign wr_en    = in_valid && !in_stall && !func;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctrl = '{cmd: DP_NOP, emit_zero: 1'b0, emit_entry: 1'b0};
        unique case (state_reg)
            S_IDLE: if (in_valid && func)
            begin
                ctrl.cmd = (entry_count == '0) ? DP_EMIT : DP_LOAD;
                ctrl.emit_zero = entry_count == '0;
            end
            S_SCAN:
            begin
                ctrl.cmd = DP_SCAN;
                if (stat.found_first)
                begin
                    ctrl.cmd = DP_EMIT;
                    ctrl.emit_entry = 1'b1;
                end
            end
            S_LAST:
            begin
                ctrl.cmd = DP_EMIT;
                ctrl.emit_entry = 1'b1;
            end
            S_RDA: ctrl.cmd = DP_RD_A;
            S_RDB: ctrl.cmd = DP_RD_B;
            S_DIV: if (!stat.div_done) ctrl.cmd = DP_DIV;
            S_MUL: if (!stat.mul_done) ctrl.cmd = DP_MUL;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (in_valid && func)
                begin
                    if (entry_count == '0)
                    begin
                        state_reg <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                    else state_reg <= S_SCAN;
                end
                S_SCAN: if (stat.scan_done)
                begin
                    if (stat.found_first)
                    begin
                        state_reg <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                    else if (stat.found_none) state_reg <= S_LAST;
                    else state_reg <= S_RDA;
                end
                S_LAST:
                begin
                    state_reg <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_RDA: state_reg <= S_RDB;
                S_RDB: state_reg <= S_DIV;
                S_DIV: if (stat.div_done) state_reg <= S_MUL;
                S_MUL: if (stat.mul_done)
                begin
                    state_reg <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT: if (!out_stall)
                begin
                    state_reg <= S_IDLE;
                    out_valid_reg <= 1'b0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT) else $error("valid outside output");
endmodule

// ----- hw/rtl/breakpoint_table_interpolator.sv -----
// top level of the breakpoint table interpolator
// depends on bti_pkg, bti_ctrl, bti_datapath
//  channel | signals                          | direction
//  in      | in_valid, in_stall, fields       | write or query word
//  out     | out_valid, out_stall, out_fields | one word per query
//  cfg     | cfg_we, cfg_wdata                | entry_count
// a write is stored when the sequencer is idle; a query's run time is set by the
// serial key scan, a 16-step restoring divider and one multiply per column
// rst_n clears the controller and entry_count; the table is undefined until written
// a stalled result holds and blocks the next word
module breakpoint_table_interpolator #(
    parameter int TABLE_DEPTH = bti_pkg::DefTableDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [3:0]  entry_index,
    input  logic [7:0]  key,
    input  logic signed [31:0] value_0, value_1, value_2, value_3,
    input  logic signed [31:0] value_4, value_5, value_6, value_7,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_key,
    output logic signed [31:0] out_value_0, out_value_1, out_value_2, out_value_3,
    output logic signed [31:0] out_value_4, out_value_5, out_value_6, out_value_7
);
    import bti_pkg::*;
    logic [CountW-1:0] count_reg;
    dp_ctrl_t ctrl;
    dp_stat_t stat;
    logic wr_en;
    logic [NumCols*ValW-1:0] rv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) count_reg <= '0;
        else if (cfg_we) count_reg <= cfg_wdata;
    end

    bti_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .func,
        .entry_count(count_reg), .out_valid, .out_stall, .ctrl, .stat, .wr_en);

    bti_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (.clk, .rst_n, .ctrl, .stat,
        .wr_en, .wr_index(entry_index), .wr_key(key),
        .wr_vals({value_7, value_6, value_5, value_4, value_3, value_2, value_1, value_0}),
        .q_key(key), .entry_count(count_reg), .res_key(out_key), .res_vals(rv));

    assign {out_value_7, out_value_6, out_value_5, out_value_4,
            out_value_3, out_value_2, out_value_1, out_value_0} = rv;
endmodule
